// File: hw/rtl/smx_pkg.sv
package smx_pkg;

    typedef struct packed {
        logic signed [15:0] score;
        logic               last_in;
    } in_t;

    typedef struct packed {
        logic [15:0] probability;
        logic        last_out;
        logic        truncated;
    } out_t;

    // operand select of the shared multiplier
    typedef enum logic [2:0] {
        MOP_NONE = 3'd0,
        MOP_Y    = 3'd1,
        MOP_P1   = 3'd2,
        MOP_P2   = 3'd3,
        MOP_P3   = 3'd4,
        MOP_R    = 3'd5
    } mop_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic idx_clr;
        logic idx_inc;
        mop_t mop;
        logic e_ld;
        logic acc;
        logic div_init;
        logic div_step;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic idx_last;
    } sts_t;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [16:0] POLY_C1   = 17'd45618;
    localparam logic [16:0] POLY_C2   = 17'd14713;
    localparam logic [16:0] POLY_C3   = 17'd5206;
    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [22:0] SUM_LIMIT = 23'h7FFFFF;
    localparam int          DIV_STEPS = 33;

endpackage

// File: hw/rtl/smx_ctrl.sv
module smx_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          last_in,
    input  smx_pkg::sts_t sts,
    output smx_pkg::cmd_t cmd,
    output logic          busy,
    output logic          emit
);

    typedef enum logic [10:0] {
        S_LOAD = 11'b00000000001,
        S_RD   = 11'b00000000010,
        S_Y    = 11'b00000000100,
        S_P1   = 11'b00000001000,
        S_P2   = 11'b00000010000,
        S_P3   = 11'b00000100000,
        S_E    = 11'b00001000000,
        S_ACC  = 11'b00010000000,
        S_DIV  = 11'b00100000000,
        S_MULR = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } state_t;

    state_t      state_reg, state_next;
    logic        pass_reg, pass_next;
    logic [5:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            pass_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mop    = smx_pkg::MOP_NONE;
        busy       = 1'b1;
        emit       = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_in)
                    begin
                        cmd.idx_clr = 1'b1;
                        pass_next   = 1'b0;
                        state_next  = S_RD;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_Y;
            end
            S_Y:
            begin
                cmd.mop    = smx_pkg::MOP_Y;
                state_next = S_P1;
            end
            S_P1:
            begin
                cmd.mop    = smx_pkg::MOP_P1;
                state_next = S_P2;
            end
            S_P2:
            begin
                cmd.mop    = smx_pkg::MOP_P2;
                state_next = S_P3;
            end
            S_P3:
            begin
                cmd.mop    = smx_pkg::MOP_P3;
                state_next = S_E;
            end
            S_E:
            begin
                cmd.e_ld   = 1'b1;
                state_next = pass_reg ? S_MULR : S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'(smx_pkg::DIV_STEPS - 1))
                begin
                    cmd.idx_clr = 1'b1;
                    pass_next   = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_MULR:
            begin
                cmd.mop    = smx_pkg::MOP_R;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                emit = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

// File: hw/rtl/smx_datapath.sv
module smx_datapath #(
    parameter int MAX_LEN = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  smx_pkg::in_t  request,
    input  smx_pkg::cmd_t cmd,
    output smx_pkg::sts_t sts,
    output smx_pkg::out_t result
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic signed [15:0] store_mem [MAX_LEN];

    logic [CW-1:0]      count_reg;
    logic signed [15:0] max_reg;
    logic [22:0]        sum_reg;
    logic               ovf_reg;
    logic [AW-1:0]      idx_reg;
    logic signed [15:0] sc_reg;
    logic [8:0]         k_reg;
    logic [16:0]        u_reg;
    logic [17:0]        p_reg;
    logic [15:0]        e_reg;
    logic [23:0]        rem_reg;
    logic [16:0]        q_reg;
    logic               first_reg;
    logic [15:0]        prob_reg;
    logic               last_reg;

    logic               full;
    logic [16:0]        mul_a, mul_b;
    logic [33:0]        prod;
    logic [15:0]        n_diff;
    logic [16:0]        m_val, m_shift;
    logic [15:0]        e_val;
    logic [23:0]        sum_add, rem_sh;
    logic [16:0]        r_use;

    assign full   = (count_reg == CW'(MAX_LEN));
    assign n_diff = 16'(max_reg - sc_reg);
    assign sts.idx_last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    // shared 17x17 multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mop)
            smx_pkg::MOP_Y:  begin mul_a = {1'b0, n_diff}; mul_b = smx_pkg::LOG2E_Q16; end
            smx_pkg::MOP_P1: begin mul_a = smx_pkg::POLY_C3; mul_b = u_reg; end
            smx_pkg::MOP_P2: begin mul_a = p_reg[16:0]; mul_b = u_reg; end
            smx_pkg::MOP_P3: begin mul_a = p_reg[16:0]; mul_b = u_reg; end
            smx_pkg::MOP_R:  begin mul_a = {1'b0, e_reg}; mul_b = r_use; end
            default:         begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign prod = 34'(mul_a) * 34'(mul_b);

    assign m_val   = p_reg[17:1];
    assign m_shift = m_val >> k_reg[4:0];
    always_comb begin
        if (k_reg >= 9'd17)
            e_val = '0;
        else if (m_shift > 17'd65535)
            e_val = 16'hFFFF;
        else
            e_val = m_shift[15:0];
    end

    assign sum_add = {1'b0, sum_reg} + {8'd0, e_reg};
    assign rem_sh  = {rem_reg[22:0], first_reg};
    // sum never drops below one full-scale exponential, so the quotient fits 17 bits
    assign r_use   = (sum_reg == '0) ? '0 : q_reg;

    always_ff @(posedge clk) begin
        if (cmd.load && !full)
            store_mem[count_reg[AW-1:0]] <= request.score;
        if (cmd.rd)
            sc_reg <= store_mem[idx_reg];
    end

    always_ff @(posedge clk) begin
        unique case (cmd.mop)
            smx_pkg::MOP_Y:
            begin
                k_reg <= prod[32:24];
                u_reg <= smx_pkg::ONE_Q16 - {1'b0, prod[23:8]};
            end
            smx_pkg::MOP_P1: p_reg <= prod[33:16] + {1'b0, smx_pkg::POLY_C2};
            smx_pkg::MOP_P2: p_reg <= prod[33:16] + {1'b0, smx_pkg::POLY_C1};
            smx_pkg::MOP_P3: p_reg <= prod[33:16] + {1'b0, smx_pkg::ONE_Q16};
            smx_pkg::MOP_R:
            begin
                prob_reg <= (prod[33:32] != 2'd0) ? 16'hFFFF : prod[31:16];
                last_reg <= sts.idx_last;
            end
            default:
            begin
            end
        endcase
        if (cmd.e_ld)
            e_reg <= e_val;
        if (cmd.div_init)
        begin
            rem_reg   <= '0;
            q_reg     <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.div_step)
        begin
            first_reg <= 1'b0;
            if (rem_sh >= {1'b0, sum_reg})
            begin
                rem_reg <= rem_sh - {1'b0, sum_reg};
                q_reg   <= {q_reg[15:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[15:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= 16'sh8000;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
                max_reg   <= 16'sh8000;
                sum_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.load)
            begin
                if (full)
                    ovf_reg <= 1'b1;
                else
                begin
                    count_reg <= count_reg + CW'(1);
                    if (request.score > max_reg)
                        max_reg <= request.score;
                end
            end
            if (cmd.acc)
                sum_reg <= sum_add[23] ? smx_pkg::SUM_LIMIT : sum_add[22:0];
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + AW'(1);
        end
    end

    assign result.probability = prob_reg;
    assign result.last_out    = last_reg;
    assign result.truncated   = ovf_reg;

endmodule

// File: hw/rtl/softmax_vector.sv
// Max-subtracted softmax. Scores load one per cycle while busy is low; the
// request marked last_in starts the passes and raises busy. The block then
// walks the buffer twice through one shared 17x17 multiplier: a first pass
// rebuilds each entry's exp and adds it to the sum, a restoring reciprocal
// division follows, then a second pass rebuilds each exp, scales it and
// presents it. Each probability shows for one cycle with result_valid
// and must be captured then; the receiver cannot stall. Scores past MAX_LEN
// are dropped and flagged in truncated on every result of that vector.
module softmax_vector #(
    parameter int MAX_LEN = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  smx_pkg::in_t  request,
    output logic          result_valid,
    output smx_pkg::out_t result
);

    smx_pkg::cmd_t cmd;
    smx_pkg::sts_t sts;

    smx_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .last_in (request.last_in),
        .sts     (sts),
        .cmd     (cmd),
        .busy    (busy),
        .emit    (result_valid)
    );

    smx_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result)
    );

endmodule
